@@ src/fbc_pkg.sv @@
// Shared types and constants for the frame builder with checksum.
`default_nettype none
package fbc_pkg;

   localparam logic       CMD_START = 1'b0;
   localparam logic       CMD_DATA  = 1'b1;

   localparam logic [7:0] LENGTH_OFFSET = 8'd10;
   localparam logic [7:0] HSB_RESET     = 8'h01;
   localparam logic [7:0] TSB_RESET     = 8'h02;

   // register select bit of the byte address
   localparam logic       REG_HSB = 1'b0;
   localparam logic       REG_TSB = 1'b1;

   // byte positions within a start item
   localparam logic [3:0] IDX_HSB   = 4'd0;
   localparam logic [3:0] IDX_LEN   = 4'd1;
   localparam logic [3:0] IDX_SRC   = 4'd2;
   localparam logic [3:0] IDX_DST   = 4'd3;
   localparam logic [3:0] IDX_TSB   = 4'd4;
   localparam logic [3:0] IDX_ID0   = 4'd5;
   localparam logic [3:0] IDX_ID1   = 4'd6;
   localparam logic [3:0] IDX_ID2   = 4'd7;
   localparam logic [3:0] IDX_ID3   = 4'd8;
   localparam logic [3:0] IDX_CKSUM = 4'd9;

   // byte positions within a data item
   localparam logic [3:0] IDX_PAYLOAD    = 4'd0;
   localparam logic [3:0] IDX_DATA_CKSUM = 4'd1;

   typedef struct packed {
      logic [7:0]  data_byte;
      logic [7:0]  payload_count;
      logic [31:0] message_id;
      logic [7:0]  dest_addr;
      logic [7:0]  source_addr;
   } item_type;

   typedef struct packed {
      logic [7:0] text_start_byte;
      logic [7:0] header_start_byte;
   } cfg_type;

   typedef struct packed {
      logic       frame_end;
      logic [7:0] out_byte;
   } out_word_type;

endpackage
`default_nettype wire

@@ src/fbc_csr.sv @@
// Configuration registers behind the APB-style port.
`default_nettype none
module fbc_csr import fbc_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output cfg_type          cfg
);

   logic [7:0] hsb_ff;
   logic [7:0] tsb_ff;
   logic       wr_en;

   assign wr_en = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         hsb_ff <= HSB_RESET;
         tsb_ff <= TSB_RESET;
      end else if (wr_en) begin
         case (csr_paddr[2])
            REG_HSB: hsb_ff <= csr_pwdata[7:0];
            REG_TSB: tsb_ff <= csr_pwdata[7:0];
            default: hsb_ff <= hsb_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[2])
         REG_HSB: csr_prdata = {24'd0, hsb_ff};
         REG_TSB: csr_prdata = {24'd0, tsb_ff};
         default: csr_prdata = 32'd0;
      endcase
   end

   assign cfg.header_start_byte = hsb_ff;
   assign cfg.text_start_byte   = tsb_ff;

endmodule
`default_nettype wire

@@ src/fbc_engine.sv @@
// Item register, frame byte sequencer and running checksum state.
`default_nettype none
module fbc_engine import fbc_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire cfg_type  cfg,
   input  wire logic     req_valid,
   output logic          req_ready,
   input  wire logic     req_cmd,
   input  wire item_type req_item,
   input  wire logic     room,
   output logic          push,
   output out_word_type  word
);

   logic       job_valid_ff;
   logic       job_cmd_ff;
   item_type   job_item_ff;
   logic [3:0] idx_ff;
   logic [7:0] sum_ff, sum_in;
   logic [7:0] left_ff, left_in;
   logic       open_ff, open_in;

   logic       accept, is_start, drop, adv, last, done;
   logic [7:0] cksum;

   assign accept    = req_valid && req_ready;
   assign is_start  = (job_cmd_ff == CMD_START);
   assign drop      = !is_start && !open_ff;
   assign adv       = job_valid_ff && (drop || room);
   assign push      = job_valid_ff && !drop && room;
   assign cksum     = ~sum_ff + 8'd1;
   assign done      = adv && last;
   assign req_ready = !job_valid_ff || done;

   always_comb begin
      word.out_byte  = cksum;
      word.frame_end = 1'b0;
      if (is_start) begin
         case (idx_ff)
            IDX_HSB:   word.out_byte = cfg.header_start_byte;
            IDX_LEN:   word.out_byte = job_item_ff.payload_count + LENGTH_OFFSET;
            IDX_SRC:   word.out_byte = job_item_ff.source_addr;
            IDX_DST:   word.out_byte = job_item_ff.dest_addr;
            IDX_TSB:   word.out_byte = cfg.text_start_byte;
            IDX_ID0:   word.out_byte = job_item_ff.message_id[31:24];
            IDX_ID1:   word.out_byte = job_item_ff.message_id[23:16];
            IDX_ID2:   word.out_byte = job_item_ff.message_id[15:8];
            IDX_ID3:   word.out_byte = job_item_ff.message_id[7:0];
            default:   word.out_byte = cksum;
         endcase
         word.frame_end = (idx_ff == IDX_CKSUM);
         if (job_item_ff.payload_count == 8'd0) begin
            last = (idx_ff == IDX_CKSUM);
         end else begin
            last = (idx_ff == IDX_ID3);
         end
      end else begin
         if (idx_ff == IDX_PAYLOAD) begin
            word.out_byte = job_item_ff.data_byte;
         end
         word.frame_end = (idx_ff != IDX_PAYLOAD);
         last = drop || word.frame_end || (left_ff != 8'd1);
      end
   end

   always_comb begin
      sum_in  = sum_ff;
      left_in = left_ff;
      open_in = open_ff;
      if (push) begin
         if (word.frame_end) begin
            sum_in  = 8'd0;
            left_in = 8'd0;
            open_in = 1'b0;
         end else begin
            if (is_start && idx_ff == IDX_HSB) begin
               sum_in = word.out_byte;
            end else begin
               sum_in = sum_ff + word.out_byte;
            end
            if (is_start && idx_ff == IDX_ID3 && job_item_ff.payload_count != 8'd0) begin
               left_in = job_item_ff.payload_count;
               open_in = 1'b1;
            end
            if (!is_start) begin
               left_in = left_ff - 8'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         job_valid_ff <= 1'b0;
         idx_ff       <= 4'd0;
         sum_ff       <= 8'd0;
         left_ff      <= 8'd0;
         open_ff      <= 1'b0;
      end else begin
         sum_ff  <= sum_in;
         left_ff <= left_in;
         open_ff <= open_in;
         if (accept) begin
            job_valid_ff <= 1'b1;
            idx_ff       <= 4'd0;
         end else begin
            if (done) begin
               job_valid_ff <= 1'b0;
            end
            if (adv) begin
               idx_ff <= idx_ff + 4'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         job_cmd_ff  <= req_cmd;
         job_item_ff <= req_item;
      end
   end

   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      job_valid_ff && is_start |-> idx_ff <= IDX_CKSUM)
      else $error("start item byte index out of range");

   a_left_nonzero: assert property (@(posedge clock) disable iff (reset)
      job_valid_ff && !is_start && open_ff && idx_ff == IDX_PAYLOAD |-> left_ff != 8'd0)
      else $error("payload word with no bytes left in open frame");

   a_close_on_end: assert property (@(posedge clock) disable iff (reset)
      push && word.frame_end |=> !open_ff && sum_ff == 8'd0)
      else $error("frame not closed after checksum word");

endmodule
`default_nettype wire

@@ src/fbc_out_fifo.sv @@
// Two-entry output skid buffer for frame words.
`default_nettype none
module fbc_out_fifo import fbc_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         push,
   input  wire out_word_type word,
   output logic              room,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [7:0]        rsp_tdata,
   output logic              rsp_tlast
);

   out_word_type entry_ff [2];
   logic         wr_ptr_ff;
   logic         rd_ptr_ff;
   logic [1:0]   count_ff;
   logic         pop;

   assign room       = (count_ff != 2'd2);
   assign rsp_tvalid = (count_ff != 2'd0);
   assign pop        = rsp_tvalid && rsp_tready;
   assign rsp_tdata  = entry_ff[rd_ptr_ff].out_byte;
   assign rsp_tlast  = entry_ff[rd_ptr_ff].frame_end;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 2'd1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= word;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> room)
      else $error("word pushed into full output buffer");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("output buffer count out of range");

endmodule
`default_nettype wire

@@ src/frame_builder_with_checksum_unit.sv @@
// Top level of the frame builder with checksum.
// A data word's payload byte passes the item register and the output buffer
// to rsp_tdata. While the buffer has room, one data word is taken per cycle,
// the last payload byte of a frame is followed by its checksum byte, and a
// start word puts out nine header bytes (ten with the checksum for a zero
// payload count), one header byte per cycle; the next word is taken in the
// cycle its last byte leaves. Data words with no frame open are consumed with
// no output. A two-word output buffer keeps rsp_tready off the req_tready path.
`default_nettype none
module frame_builder_with_checksum_unit import fbc_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // [7:0] source_addr, [15:8] dest_addr, [47:16] message_id,
   // [55:48] payload_count, [63:56] data_byte
   input  wire logic [63:0] req_tdata,
   // [0] command
   input  wire logic        req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [7:0] out_byte
   output logic [7:0]       rsp_tdata,
   output logic             rsp_tlast,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   cfg_type      cfg;
   item_type     req_item;
   out_word_type word;
   logic         room;
   logic         push;

   assign csr_pready = 1'b1;
   assign req_item   = item_type'(req_tdata);

   fbc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .cfg         (cfg)
   );

   fbc_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req_cmd   (req_tuser),
      .req_item  (req_item),
      .room      (room),
      .push      (push),
      .word      (word)
   );

   fbc_out_fifo u_out_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .word       (word),
      .room       (room),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
`default_nettype wire
